// ===== rtl/bvd_pkg.sv =====
// Package for the BER value decoder: codes, queue entry type and helpers.
// Used by every module of the block; depends on nothing.
package bvd_pkg;

   // Decoder phases
   typedef enum logic [2:0] {
      PH_TAG,
      PH_LEN_FIRST,
      PH_LEN_MORE,
      PH_INT,
      PH_STR,
      PH_DROP
   } phase_type;

   // Work handed from front to back
   typedef enum logic [2:0] {
      OP_ACC,        // integer content byte, no result
      OP_INT_DONE,   // last integer content byte, emit value
      OP_INT_ZERO,   // zero-length integer, emit 0
      OP_STR_BYTE,   // octet string byte
      OP_STR_EMPTY,  // zero-length string
      OP_ERROR       // error result
   } op_type;

   // Value types
   localparam logic [2:0] TYPE_INT       = 3'd0;
   localparam logic [2:0] TYPE_IPV4      = 3'd1;
   localparam logic [2:0] TYPE_COUNTER   = 3'd2;
   localparam logic [2:0] TYPE_GAUGE     = 3'd3;
   localparam logic [2:0] TYPE_COUNTER64 = 3'd4;
   localparam logic [2:0] TYPE_OCTETS    = 3'd5;

   // Result kinds
   localparam logic [1:0] KIND_INT       = 2'd0;
   localparam logic [1:0] KIND_STR_BYTE  = 2'd1;
   localparam logic [1:0] KIND_ERROR     = 2'd2;
   localparam logic [1:0] KIND_STR_EMPTY = 2'd3;

   // Error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_PROTOCOL  = 2'd1;
   localparam logic [1:0] ERR_TOO_SMALL = 2'd2;

   // BER tags
   localparam logic [7:0] TAG_INTEGER   = 8'h02;
   localparam logic [7:0] TAG_OCTETS    = 8'h04;
   localparam logic [7:0] TAG_IPV4      = 8'h40;
   localparam logic [7:0] TAG_COUNTER   = 8'h41;
   localparam logic [7:0] TAG_GAUGE     = 8'h42;
   localparam logic [7:0] TAG_COUNTER64 = 8'h46;

   localparam int         LEN_LONG_BIT  = 7;      // 0x80: long-form length
   localparam logic [6:0] MAX_LEN_BYTES = 7'd4;   // low 7 bits (0x7F) give the count

   localparam logic [15:0] DEST_CAPACITY_RESET = 16'd8;
   localparam int          QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      op_type      op;
      logic [2:0]  vtype;
      logic [7:0]  data;
      logic [15:0] size;
      logic [1:0]  err;
      logic        last;
   } entry_type;

   function automatic logic [15:0] int_slot_bytes(input logic [2:0] vtype);
      return (vtype == TYPE_COUNTER64) ? 16'd8 : 16'd4;
   endfunction

endpackage

// ===== rtl/bvd_if.sv =====
// Channel interfaces of the BER value decoder: byte input, result output, CSR write.
// Plain valid/ready channels; no package dependency.
interface bvd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_buffer;

   modport source (output valid, output in_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface bvd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_kind;
   logic [2:0]  value_type;
   logic [63:0] out_value;
   logic [15:0] value_size;
   logic [1:0]  error_code;
   logic        value_last;

   modport source (output valid, output out_kind, output value_type, output out_value,
                   output value_size, output error_code, output value_last, input ready);
   modport sink   (input valid, input out_kind, input value_type, input out_value,
                   input value_size, input error_code, input value_last, output ready);
endinterface

interface bvd_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] dest_capacity;

   modport source (output valid, output dest_capacity, input ready);
   modport sink   (input valid, input dest_capacity, output ready);
endinterface

// ===== rtl/bvd_front.sv =====
// Front end: takes bytes, runs the tag/length/content state machine, holds the
// capacity register and queues one work entry per byte that needs the back end. Uses bvd_pkg.
module bvd_front (
   input  logic                clock,
   input  logic                reset,
   bvd_req_if.sink             req,
   bvd_csr_if.sink             csr,
   input  logic                q_full,
   output logic                push_valid,
   output bvd_pkg::entry_type  push_entry
);
   import bvd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  type_ff, type_in;
   logic [2:0]  lbl_ff, lbl_in;
   logic [31:0] clen_ff, clen_in;
   logic [31:0] cleft_ff, cleft_in;
   logic [15:0] cap_ff;
   logic        accept;
   logic        push;
   entry_type   ent;

   assign req.ready  = !q_full;
   assign accept     = req.valid && req.ready;
   assign csr.ready  = 1'b1;
   assign push_valid = accept && push;
   assign push_entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         type_ff  <= TYPE_INT;
         lbl_ff   <= '0;
         clen_ff  <= '0;
         cleft_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         lbl_ff   <= lbl_in;
         clen_ff  <= clen_in;
         cleft_ff <= cleft_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= DEST_CAPACITY_RESET;
      end else if (csr.valid) begin
         cap_ff <= csr.dest_capacity;
      end
   end

   always_comb begin
      logic [7:0]  b;
      logic        tag_ok;
      logic [2:0]  t;
      logic        len_known;
      logic [31:0] len_val;

      b         = req.in_byte;
      tag_ok    = 1'b1;
      t         = TYPE_INT;
      len_known = 1'b0;
      len_val   = '0;
      phase_in  = phase_ff;
      type_in   = type_ff;
      lbl_in    = lbl_ff;
      clen_in   = clen_ff;
      cleft_in  = cleft_ff;
      push      = 1'b0;
      ent.op    = OP_ACC;
      ent.data  = b;
      ent.size  = '0;
      ent.err   = ERR_NONE;
      ent.last  = 1'b0;

      case (phase_ff)
         PH_TAG: begin
            case (b)
               TAG_INTEGER:   t = TYPE_INT;
               TAG_IPV4:      t = TYPE_IPV4;
               TAG_COUNTER:   t = TYPE_COUNTER;
               TAG_GAUGE:     t = TYPE_GAUGE;
               TAG_COUNTER64: t = TYPE_COUNTER64;
               TAG_OCTETS:    t = TYPE_OCTETS;
               default:       tag_ok = 1'b0;
            endcase
            type_in = t;
            if (!tag_ok) begin
               push     = 1'b1;
               ent.op   = OP_ERROR;
               ent.err  = ERR_PROTOCOL;
               ent.last = 1'b1;
               phase_in = PH_DROP;
            end else if (t != TYPE_OCTETS && cap_ff < int_slot_bytes(t)) begin
               push     = 1'b1;
               ent.op   = OP_ERROR;
               ent.err  = ERR_TOO_SMALL;
               ent.last = 1'b1;
               phase_in = PH_DROP;
            end else begin
               clen_in  = '0;
               phase_in = PH_LEN_FIRST;
            end
         end
         PH_LEN_FIRST: begin
            if (!b[LEN_LONG_BIT]) begin
               len_known = 1'b1;
               len_val   = {24'd0, b};
            end else if (b[6:0] > MAX_LEN_BYTES) begin
               push     = 1'b1;
               ent.op   = OP_ERROR;
               ent.err  = ERR_PROTOCOL;
               ent.last = 1'b1;
               phase_in = PH_DROP;
            end else if (b[6:0] == 7'd0) begin
               len_known = 1'b1;
            end else begin
               clen_in  = '0;
               lbl_in   = b[2:0];
               phase_in = PH_LEN_MORE;
            end
         end
         PH_LEN_MORE: begin
            len_val = {clen_ff[23:0], b};
            clen_in = len_val;
            lbl_in  = lbl_ff - 3'd1;
            if (lbl_ff == 3'd1) begin
               len_known = 1'b1;
            end
         end
         PH_INT: begin
            push     = 1'b1;
            cleft_in = cleft_ff - 32'd1;
            if (cleft_ff == 32'd1) begin
               ent.op   = OP_INT_DONE;
               ent.size = int_slot_bytes(type_ff);
               ent.last = 1'b1;
               phase_in = PH_TAG;
            end
         end
         PH_STR: begin
            push     = 1'b1;
            cleft_in = cleft_ff - 32'd1;
            ent.op   = OP_STR_BYTE;
            ent.size = clen_ff[15:0];
            ent.last = (cleft_ff == 32'd1);
            if (cleft_ff == 32'd1) begin
               phase_in = PH_TAG;
            end
         end
         PH_DROP: begin
         end
         default: begin
            phase_in = PH_TAG;
         end
      endcase

      // length settled: decide content handling
      if (len_known) begin
         clen_in = len_val;
         if (type_ff != TYPE_OCTETS) begin
            if (len_val == 32'd0) begin
               push     = 1'b1;
               ent.op   = OP_INT_ZERO;
               ent.size = int_slot_bytes(type_ff);
               ent.last = 1'b1;
               phase_in = PH_TAG;
            end else begin
               cleft_in = len_val;
               phase_in = PH_INT;
            end
         end else if (len_val > {16'd0, cap_ff}) begin
            push     = 1'b1;
            ent.op   = OP_ERROR;
            ent.err  = ERR_TOO_SMALL;
            ent.last = 1'b1;
            phase_in = PH_DROP;
         end else if (len_val == 32'd0) begin
            push     = 1'b1;
            ent.op   = OP_STR_EMPTY;
            ent.last = 1'b1;
            phase_in = PH_TAG;
         end else begin
            cleft_in = len_val;
            phase_in = PH_STR;
         end
      end

      // buffer ends: a value in flight turns into a too-small error
      if (req.end_of_buffer) begin
         if (phase_in != PH_TAG && phase_in != PH_DROP) begin
            push     = 1'b1;
            ent.op   = OP_ERROR;
            ent.size = '0;
            ent.err  = ERR_TOO_SMALL;
            ent.last = 1'b1;
         end
         phase_in = PH_TAG;
      end

      ent.vtype = type_in;
   end

`ifndef ASSERT_OFF
   a_eob_to_tag: assert property (@(posedge clock) disable iff (reset)
      (accept && req.end_of_buffer) |=> (phase_ff == PH_TAG))
      else $error("phase not back at tag after end of buffer");
`endif

endmodule

// ===== rtl/bvd_queue.sv =====
// Short FIFO of work entries between front and back ends.
// Uses bvd_pkg for the entry type.
module bvd_queue #(
   parameter int DEPTH = bvd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bvd_pkg::entry_type  push_entry,
   input  logic                pop,
   output bvd_pkg::entry_type  head,
   output logic                full,
   output logic                empty
);
   import bvd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
`endif
`ifndef ASSERT_OFF
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/bvd_back.sv =====
// Back end: drains the work queue, accumulates integer content and drives
// the registered result channel. Uses bvd_pkg.
module bvd_back (
   input  logic                clock,
   input  logic                reset,
   input  bvd_pkg::entry_type  head,
   input  logic                q_empty,
   output logic                pop,
   bvd_rsp_if.source           rsp
);
   import bvd_pkg::*;

   logic [63:0] acc_ff, acc_in;
   logic [63:0] acc_shift;
   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [2:0]  vtype_ff;
   logic [63:0] value_ff, value_in;
   logic [15:0] size_ff;
   logic [1:0]  err_ff;
   logic        last_ff;
   logic        head_acc;
   logic        load;

   assign head_acc  = !q_empty && (head.op == OP_ACC);
   assign load      = !q_empty && !head_acc && (!valid_ff || rsp.ready);
   assign pop       = head_acc || load;
   // big-endian accumulate; only the low 32 bits survive outside Counter64
   assign acc_shift = (head.vtype == TYPE_COUNTER64) ? {acc_ff[55:0], head.data}
                                                     : {32'd0, acc_ff[23:0], head.data};

   always_comb begin
      acc_in   = acc_ff;
      valid_in = rsp.ready ? 1'b0 : valid_ff;
      kind_in  = KIND_ERROR;
      value_in = '0;
      case (head.op)
         OP_INT_DONE: begin
            kind_in  = KIND_INT;
            value_in = acc_shift;
         end
         OP_INT_ZERO:  kind_in = KIND_INT;
         OP_STR_BYTE: begin
            kind_in  = KIND_STR_BYTE;
            value_in = {56'd0, head.data};
         end
         OP_STR_EMPTY: kind_in = KIND_STR_EMPTY;
         OP_ERROR:     kind_in = KIND_ERROR;
         default:      kind_in = KIND_ERROR;
      endcase
      if (head_acc) begin
         acc_in = acc_shift;
      end
      if (load) begin
         acc_in   = '0;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         vtype_ff <= head.vtype;
         value_ff <= value_in;
         size_ff  <= head.size;
         err_ff   <= head.err;
         last_ff  <= head.last;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.out_kind   = kind_ff;
   assign rsp.value_type = vtype_ff;
   assign rsp.out_value  = value_ff;
   assign rsp.value_size = size_ff;
   assign rsp.error_code = err_ff;
   assign rsp.value_last = last_ff;

`ifndef ASSERT_OFF
   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      load |=> (acc_ff == 64'd0))
      else $error("accumulator not cleared after a result");
`endif

endmodule

// ===== rtl/ber_value_decoder_top.sv =====
// BER value decoder top: one SNMP BER value per item stream, one byte per item.
// With the queue empty, a taken byte's result is written into a queue entry and then loaded
// into the result register, which drives rsp.
// Throughput: one byte per cycle while the work queue is not full, as the front end updates its state once per byte.
// Bytes keep flowing while a result waits; the work queue absorbs up to QUEUE_DEPTH entries.
// Reset (synchronous, active high) returns to expecting a tag, empties the queue and the
// result register and sets dest_capacity to 8; there is no clearing pass.
module ber_value_decoder_top #(
   parameter int QUEUE_DEPTH = bvd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   bvd_req_if.sink   req,
   bvd_rsp_if.source rsp,
   bvd_csr_if.sink   csr
);
   import bvd_pkg::*;

   // front -> queue
   logic      push_valid;
   entry_type push_entry;
   logic      q_full;

   // queue -> back
   entry_type head_entry;
   logic      q_empty;
   logic      pop;

   // Front: tag and length parsing, capacity checks, end-of-buffer handling.
   // Emits one entry per byte that carries content or a result.
   bvd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr        (csr),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // Decouples parsing from result delivery so a stalled sink does not stop input at once.
   bvd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   // Back: integer accumulation and the output register.
   // Integer content bytes drain without waiting on the sink; result entries, string bytes among them, wait for it.
   bvd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head_entry),
      .q_empty (q_empty),
      .pop     (pop),
      .rsp     (rsp)
   );

endmodule

// ===== dv/tb_ber_value_decoder_top.sv =====
// Self-checking testbench for ber_value_decoder_top: byte streams of SNMP BER values in,
// decoded values, string bytes and errors out, each checked against an in-bench decoder.
// Depends on bvd_pkg, the bvd_*_if channel interfaces and the decoder top level.
module tb_ber_value_decoder_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bvd_pkg::*;

   // Long-form length marker; low 7 bits then give the count of length bytes
   localparam logic [7:0] LEN_LONG_FORM = 8'h80;
   // A result goes through the queue and result register; allow for queued work with no result too
   localparam int SETTLE_CYCLES = 16;
   // Longest honest silence is the receiver hold-off of test_backpressure; take it many times over
   localparam int IDLE_LIMIT    = 2000;

   // One decoder output as it appears on the result channel
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  vtype;
      logic [63:0] value;
      logic [15:0] vsize;
      logic [1:0]  err;
      logic        last;
   } decoded_type;

   logic clock;
   logic reset;

   bvd_req_if req_ch ();
   bvd_rsp_if rsp_ch ();
   bvd_csr_if csr_ch ();

   ber_value_decoder_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // ---------------------------------------------------------------------------------------
   // Shared state
   // ---------------------------------------------------------------------------------------
   decoded_type decoded_q[$];     // outputs the decoder owes us, oldest first
   logic [7:0]  pkt_bytes[$];     // buffer being assembled before it is sent
   int          n_errors;
   int          idle_cycles;
   bit          req_gaps_on;      // sender idles between items
   bit          rsp_stalls_on;    // receiver drops ready at random
   int          rsp_hold_cycles;  // one-off long hold-off, picked up by the receiver

   // In-bench decoder state, mirrors the block after each accepted item
   phase_type   dec_phase;
   logic [2:0]  dec_type;
   logic [2:0]  len_left;
   logic [31:0] content_len;
   logic [31:0] content_rem;
   logic [63:0] acc;
   logic [15:0] capacity;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Decoder model
   // ---------------------------------------------------------------------------------------
   function automatic logic [15:0] int_bytes(input logic [2:0] t);
      return (t == TYPE_COUNTER64) ? 16'd8 : 16'd4;
   endfunction

   function automatic decoded_type make_result(input logic [1:0] kind,
                                               input logic [63:0] value,
                                               input logic [15:0] vsize, input logic [1:0] err,
                                               input logic last);
      decoded_type r;
      r.kind  = kind;
      r.vtype = dec_type;
      r.value = value;
      r.vsize = vsize;
      r.err   = err;
      r.last  = last;
      return r;
   endfunction

   // Error result; everything up to the end of the buffer is then thrown away
   function automatic decoded_type fail_with(input logic [1:0] code);
      dec_phase = PH_DROP;
      return make_result(KIND_ERROR, 64'd0, 16'd0, code, 1'b1);
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic eob);
      decoded_type r;
      bit          has;
      bit          len_done;
      bit          tag_ok;
      r        = '0;
      has      = 1'b0;
      len_done = 1'b0;
      tag_ok   = 1'b1;
      case (dec_phase)
         PH_TAG: begin
            case (b)
               TAG_INTEGER:   dec_type = TYPE_INT;
               TAG_IPV4:      dec_type = TYPE_IPV4;
               TAG_COUNTER:   dec_type = TYPE_COUNTER;
               TAG_GAUGE:     dec_type = TYPE_GAUGE;
               TAG_COUNTER64: dec_type = TYPE_COUNTER64;
               TAG_OCTETS:    dec_type = TYPE_OCTETS;
               default:       tag_ok = 1'b0;
            endcase
            if (!tag_ok) begin
               dec_type = TYPE_INT;
               r = fail_with(ERR_PROTOCOL);
               has = 1'b1;
            end else if (dec_type != TYPE_OCTETS && capacity < int_bytes(dec_type)) begin
               r = fail_with(ERR_TOO_SMALL);
               has = 1'b1;
            end else begin
               acc = '0;
               content_len = '0;
               dec_phase = PH_LEN_FIRST;
            end
         end
         PH_LEN_FIRST: begin
            if (!b[LEN_LONG_BIT]) begin
               content_len = {24'd0, b};
               len_done = 1'b1;
            end else if (b[6:0] > MAX_LEN_BYTES) begin
               r = fail_with(ERR_PROTOCOL);
               has = 1'b1;
            end else if (b[6:0] == 7'd0) begin
               content_len = '0;
               len_done = 1'b1;
            end else begin
               content_len = '0;
               len_left = b[2:0];
               dec_phase = PH_LEN_MORE;
            end
         end
         PH_LEN_MORE: begin
            content_len = {content_len[23:0], b};
            len_left = len_left - 3'd1;
            if (len_left == 3'd0) len_done = 1'b1;
         end
         PH_INT: begin
            acc = {acc[55:0], b};
            if (dec_type != TYPE_COUNTER64) acc[63:32] = '0;
            content_rem = content_rem - 32'd1;
            if (content_rem == 32'd0) begin
               dec_phase = PH_TAG;
               r = make_result(KIND_INT, acc, int_bytes(dec_type), ERR_NONE, 1'b1);
               has = 1'b1;
            end
         end
         PH_STR: begin
            content_rem = content_rem - 32'd1;
            r = make_result(KIND_STR_BYTE, {56'd0, b}, content_len[15:0], ERR_NONE,
                            content_rem == 32'd0);
            has = 1'b1;
            if (content_rem == 32'd0) dec_phase = PH_TAG;
         end
         default: ;
      endcase

      // Length now known: finish at once on zero length, else go on to the content
      if (len_done) begin
         if (dec_type != TYPE_OCTETS) begin
            if (content_len == 32'd0) begin
               acc = '0;
               dec_phase = PH_TAG;
               r = make_result(KIND_INT, 64'd0, int_bytes(dec_type), ERR_NONE, 1'b1);
               has = 1'b1;
            end else begin
               content_rem = content_len;
               dec_phase = PH_INT;
            end
         end else if (content_len > {16'd0, capacity}) begin
            r = fail_with(ERR_TOO_SMALL);
            has = 1'b1;
         end else if (content_len == 32'd0) begin
            dec_phase = PH_TAG;
            r = make_result(KIND_STR_EMPTY, 64'd0, 16'd0, ERR_NONE, 1'b1);
            has = 1'b1;
         end else begin
            content_rem = content_len;
            dec_phase = PH_STR;
         end
      end

      // Buffer ran out mid-value: this byte's result becomes a too-small error
      if (eob) begin
         if (dec_phase != PH_TAG && dec_phase != PH_DROP) begin
            r = make_result(KIND_ERROR, 64'd0, 16'd0, ERR_TOO_SMALL, 1'b1);
            has = 1'b1;
         end
         dec_phase = PH_TAG;
      end

      if (has) decoded_q.push_back(r);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Driving helpers
   // ---------------------------------------------------------------------------------------
   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // Offer one byte, wait for it to be taken, then maybe idle. valid stays high when
   // no gap follows, so back-to-back items never lower and raise it in one step.
   task automatic send_byte(input logic [7:0] b, input logic eob);
      int gap;
      req_ch.valid         <= 1'b1;
      req_ch.in_byte       <= b;
      req_ch.end_of_buffer <= eob;
      do @(posedge clock); while (!req_ch.ready);
      decode_byte(b, eob);
      gap = 0;
      if (req_gaps_on && $urandom_range(0, 1) == 1) gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Send the assembled buffer; its last byte carries end_of_buffer
   task automatic send_packet();
      foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
      pkt_bytes.delete();
   endtask

   // Stop offering and wait until every owed output has come, plus a short settle
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called with the decoder idle
   task automatic write_capacity(input logic [15:0] cap);
      csr_ch.valid         <= 1'b1;
      csr_ch.dest_capacity <= cap;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      capacity = cap;
   endtask

   // Push the low n bytes of v, most significant first
   function automatic void append_bytes(input int n, input logic [63:0] v);
      for (int i = n - 1; i >= 0; i--) pkt_bytes.push_back(v[8*i +: 8]);
   endfunction

   function automatic logic [7:0] tag_of(input int i);
      case (i)
         0:       return TAG_INTEGER;
         1:       return TAG_IPV4;
         2:       return TAG_COUNTER;
         3:       return TAG_GAUGE;
         4:       return TAG_COUNTER64;
         default: return TAG_OCTETS;
      endcase
   endfunction

   // Any legal length encoding: short, long (minimal or zero-padded) or bare 0x80 for zero
   function automatic void append_length(input int len);
      int r;
      int nb;
      int min_nb;
      r = $urandom_range(0, 3);
      if (len == 0 && r == 0) begin
         pkt_bytes.push_back(LEN_LONG_FORM);
      end else if (len < 128 && r <= 1) begin
         pkt_bytes.push_back(8'(len));
      end else begin
         min_nb = (len < 256) ? 1 : (len < 65536) ? 2 : (len < 16777216) ? 3 : 4;
         nb = $urandom_range(min_nb, 4);
         pkt_bytes.push_back(LEN_LONG_FORM | 8'(nb));
         for (int i = nb - 1; i >= 0; i--) pkt_bytes.push_back(8'(len >> (8 * i)));
      end
   endfunction

   function automatic void append_random_bytes(input int n);
      repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   // Well-formed value with random content; may still trip the capacity check
   function automatic void append_well_formed();
      int t;
      int len;
      int str_max;
      t = $urandom_range(0, 5);
      if (tag_of(t) == TAG_OCTETS) begin
         str_max = (int'(capacity) + 2 < 20) ? int'(capacity) + 2 : 20;
         if (capacity >= 16'd300 && $urandom_range(0, 19) == 0) len = $urandom_range(100, 300);
         else len = $urandom_range(0, str_max);
      end else if (tag_of(t) == TAG_COUNTER64) begin
         len = $urandom_range(0, 10);   // past 8 only the low 64 bits survive
      end else begin
         len = $urandom_range(0, 6);    // past 4 only the low 32 bits survive
      end
      pkt_bytes.push_back(tag_of(t));
      append_length(len);
      append_random_bytes(len);
   endfunction

   // Returns 1 when the value leaves the decoder discarding or mid-value, so the
   // buffer should end here
   function automatic bit append_random_value();
      int start;
      int n;
      if ($urandom_range(0, 99) < 85) begin
         append_well_formed();
         return 1'b0;
      end
      case ($urandom_range(0, 3))
         0: begin   // random tag byte, mostly unknown
            append_random_bytes(1 + $urandom_range(0, 3));
         end
         1: begin   // too many length bytes
            pkt_bytes.push_back(tag_of($urandom_range(0, 5)));
            pkt_bytes.push_back(LEN_LONG_FORM | 8'($urandom_range(5, 127)));
            append_random_bytes($urandom_range(0, 3));
         end
         2: begin   // huge four-byte length, cut short by the buffer end
            pkt_bytes.push_back(tag_of($urandom_range(0, 5)));
            pkt_bytes.push_back(LEN_LONG_FORM | 8'd4);
            append_random_bytes(4 + $urandom_range(0, 5));
         end
         default: begin   // well-formed value truncated somewhere after its tag
            start = pkt_bytes.size();
            append_well_formed();
            n = pkt_bytes.size() - start;
            if (n > 1) repeat ($urandom_range(1, n - 1)) void'(pkt_bytes.pop_back());
         end
      endcase
      return 1'b1;
   endfunction

   task automatic send_random_packet(output int n_sent);
      int n_values;
      n_values = $urandom_range(1, 4);
      for (int v = 0; v < n_values; v++)
         if (append_random_value()) break;
      n_sent = pkt_bytes.size();
      send_packet();
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------
   // Every tag, long and short length forms, zero lengths, empty string, byte extremes
   task automatic test_value_types();
      append_bytes(4, {TAG_INTEGER, LEN_LONG_FORM | 8'd1, 8'h01, 8'hFF});
      append_bytes(6, {TAG_IPV4, 8'h04, 8'hC0, 8'hA8, 8'h00, 8'h01});
      append_bytes(2, {TAG_COUNTER, LEN_LONG_FORM});      // long form, no length bytes
      append_bytes(2, {TAG_GAUGE, 8'h00});                // zero-length integer
      append_bytes(2, {TAG_COUNTER64, 8'h00});
      append_bytes(2, {TAG_OCTETS, 8'h00});               // empty string
      append_bytes(4, {TAG_OCTETS, 8'h02, 8'h00, 8'hFF});
      send_packet();
   endtask

   task automatic test_protocol_errors();
      append_bytes(2, {8'hFF, 8'h7F});                          // unknown tag, then discard
      send_packet();
      append_bytes(2, {TAG_INTEGER, LEN_LONG_FORM | 8'd5});     // five length bytes
      send_packet();
      append_bytes(4, {TAG_OCTETS, 8'h09, 8'h41, 8'h42});       // string over capacity
      send_packet();
      append_bytes(3, {TAG_INTEGER, 8'h02, 8'h01});             // buffer ends mid-value
      send_packet();
   endtask

   // Integer slots against small capacities, strings right at and over the limit
   task automatic test_capacity_limits();
      wait_drained();
      write_capacity(16'd3);
      append_bytes(3, {TAG_INTEGER, 8'h01, 8'h05});             // refused at the tag
      send_packet();
      append_bytes(5, {TAG_OCTETS, 8'h03, 8'hAA, 8'hBB, 8'hCC});
      send_packet();
      wait_drained();
      write_capacity(16'd7);
      append_bytes(1, {TAG_COUNTER64});                         // error and buffer end at once
      send_packet();
      append_bytes(3, {TAG_GAUGE, 8'h01, 8'h80});
      send_packet();
      wait_drained();
      write_capacity(16'd0);
      append_bytes(2, {TAG_OCTETS, 8'h00});
      send_packet();
      append_bytes(3, {TAG_OCTETS, 8'h01, 8'h55});
      send_packet();
   endtask

   // Receiver holds off while a long string streams in, so the block backs up and
   // stalls its input; then the sender waits for everything to drain
   task automatic test_backpressure();
      wait_drained();
      write_capacity(16'hFFFF);
      req_gaps_on     = 1'b0;
      rsp_hold_cycles = 150;
      append_bytes(2, {TAG_OCTETS, 8'd48});
      append_random_bytes(48);
      append_bytes(3, {TAG_INTEGER, 8'h01, 8'h7F});
      send_packet();
      wait_drained();
      req_gaps_on = 1'b1;
   endtask

   task automatic run_random_phase(input logic [15:0] cap, input int n_target, input bit quiet);
      int sent;
      int n;
      wait_drained();
      write_capacity(cap);
      req_gaps_on   = !quiet;
      rsp_stalls_on = !quiet;
      sent = 0;
      while (sent < n_target) begin
         send_random_packet(n);
         sent += n;
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   task automatic test_random();
      run_random_phase(16'd0, 240, 1'b0);
      run_random_phase(16'd3, 240, 1'b0);
      run_random_phase(16'd4, 240, 1'b0);
      run_random_phase(16'd7, 240, 1'b0);
      run_random_phase(16'hFFFF, 240, 1'b1);          // no idling on either side
      run_random_phase(DEST_CAPACITY_RESET, 240, 1'b0);
      run_random_phase(16'($urandom_range(9, 65534)), 240, 1'b0);
   endtask

   // ---------------------------------------------------------------------------------------
   // Receiver: random stalls, plus the long hold-off counted here
   // ---------------------------------------------------------------------------------------
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            stall_left = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap() - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result checking: each output against the oldest owed one, field by field
   // ---------------------------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         n_errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      decoded_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (decoded_q.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected output, expected none, actual kind %0d type %0d value %0h",
                     $realtime, rsp_ch.out_kind, rsp_ch.value_type, rsp_ch.out_value);
         end else begin
            want = decoded_q.pop_front();
            check_field("out_kind",   want.kind,  rsp_ch.out_kind);
            check_field("value_type", want.vtype, rsp_ch.value_type);
            check_field("out_value",  want.value, rsp_ch.out_value);
            check_field("value_size", want.vsize, rsp_ch.value_size);
            check_field("error_code", want.err,   rsp_ch.error_code);
            check_field("value_last", want.last,  rsp_ch.value_last);
         end
      end
   end

   // Watchdog: too long with no handshake on any channel ends the run
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
         $display("FAIL ber_value_decoder_top");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      n_errors        = 0;
      idle_cycles     = 0;
      req_gaps_on     = 1'b1;
      rsp_stalls_on   = 1'b1;
      rsp_hold_cycles = 0;
      // model starts where reset leaves the block
      dec_phase   = PH_TAG;
      dec_type    = TYPE_INT;
      len_left    = '0;
      content_len = '0;
      content_rem = '0;
      acc         = '0;
      capacity    = DEST_CAPACITY_RESET;

      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.in_byte       <= '0;
      req_ch.end_of_buffer <= 1'b0;
      csr_ch.valid         <= 1'b0;
      csr_ch.dest_capacity <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_value_types();
      test_protocol_errors();
      test_capacity_limits();
      test_backpressure();
      test_random();
      wait_drained();

      if (n_errors == 0 && decoded_q.size() == 0) begin
         $display("PASS ber_value_decoder_top");
      end else begin
         $display("FAIL ber_value_decoder_top");
      end
      $finish;
   end

endmodule
